FILE: rtl/omcu_pkg.sv
`timescale 1ns / 1ps

package omcu_pkg;

    localparam int ACC_W = 40;
    localparam int V_W   = 48;
    localparam int DIV_W = 48;

    localparam logic [2:0] CMD_LOAD_Q = 3'd0;
    localparam logic [2:0] CMD_LOAD_P = 3'd1;
    localparam logic [2:0] CMD_LOAD_N = 3'd2;
    localparam logic [2:0] CMD_TRAIN  = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    localparam logic signed [31:0] Q_ONE   = 32'sd65536;
    localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

    typedef enum logic [3:0] {
        MS_M_P, MS_M_N, MS_Q_TP, MS_Q_TN, MS_Q_D, MS_X_X,
        MS_T_S, MS_MM_S, MS_T_X, MS_S_X, MS_T_T, MS_MS_T
    } t_mul_sel;

    typedef enum logic [3:0] {
        WB_NONE, WB_TP, WB_TN, WB_ACCP, WB_ACCN, WB_X, WB_T1, WB_V, WB_S
    } t_wb_sel;

    typedef enum logic [1:0] {
        OUT_ZERO, OUT_MODEL, OUT_TRAIN
    } t_out_sel;

    typedef struct packed {
        logic     capture;
        logic     vec_wr;
        logic     vec_clr;
        logic     rd_model;
        logic     rd_elem;
        logic     cnt_clr;
        logic     cnt_step;
        logic     init_wr;
        logic     acc_clr;
        logic     margin_ld;
        logic     div_go;
        logic     div_m;
        logic     ld_mulm;
        logic     ld_muls;
        logic     mul_en;
        logic     wr_m;
        logic     out_ld;
        t_mul_sel mul_sel;
        t_wb_sel  wb_sel;
        t_out_sel out_sel;
    } t_ctl;

    typedef struct packed {
        logic [2:0] cmd;
        logic       last_j;
        logic       last_k;
        logic       hinge;
        logic       div_busy;
    } t_stat;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = SAT_MAX;
        end else if (v < -66'sd2147483648) begin
            r = SAT_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/omcu_div.sv
`timescale 1ns / 1ps

module omcu_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [omcu_pkg::DIV_W-1:0] i_dividend,
    input  logic [omcu_pkg::DIV_W-1:0] i_divisor,
    output logic                       o_busy,
    output logic [omcu_pkg::DIV_W-1:0] o_quotient
);
    import omcu_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_dvs;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W+1:0] diff;

    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_dvs};

    // restoring division, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DIV_W);
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            if (!diff[DIV_W+1]) begin
                r_rem <= diff[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/omcu_datapath.sv
`timescale 1ns / 1ps

module omcu_datapath #(
    parameter int DIM = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  omcu_pkg::t_ctl      i_ctl,
    output omcu_pkg::t_stat     o_stat,
    input  logic                i_cfg_we,
    input  logic [30:0]         i_cfg_wdata,
    input  logic [2:0]          i_command,
    input  logic [3:0]          i_row,
    input  logic [3:0]          i_column,
    input  logic signed [31:0]  i_element_value,
    input  logic signed [1:0]   i_label,
    output logic signed [31:0]  o_margin,
    output logic                o_updated,
    output logic signed [31:0]  o_model_value
);
    import omcu_pkg::*;

    localparam int IW    = $clog2(DIM);
    localparam int DEPTH = DIM * DIM;
    localparam int KW    = $clog2(DEPTH);
    localparam int EW    = IW + 4;

    // request fields
    logic [2:0]         r_cmd;
    logic [3:0]         r_row;
    logic [3:0]         r_col;
    logic signed [31:0] r_val;
    logic signed [1:0]  r_y;
    logic [30:0]        r_reg;

    logic [IW-1:0] r_i;
    logic [IW-1:0] r_j;
    logic [KW-1:0] r_k;

    logic signed [31:0] mem_m [DEPTH];
    logic signed [31:0] mem_s [DEPTH];
    logic signed [31:0] vec_q [DIM];
    logic signed [31:0] vec_p [DIM];
    logic signed [31:0] vec_n [DIM];
    logic [DIM-1:0]     r_qv;
    logic [DIM-1:0]     r_pv;
    logic [DIM-1:0]     r_nv;

    logic signed [31:0] r_m, r_s, r_q, r_p, r_n;
    logic               r_rd_ok;
    logic signed [64:0] r_prod;
    logic signed [ACC_W-1:0] r_tp, r_tn, r_accp, r_accn;
    logic signed [V_W-1:0]   r_v;
    logic signed [31:0] r_x, r_t1, r_mulm, r_muls, r_margin, r_loss;
    logic               r_hinge;

    logic [EW-1:0]      col_ext, row_ext;
    logic               col_ok, row_ok;
    logic [IW-1:0]      col_idx;
    logic [KW-1:0]      model_addr, rd_addr;
    logic signed [31:0] mulq_val;
    logic signed [31:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [31:0] sat_tp, sat_tn;
    logic signed [31:0] sp, sn, p_val;
    logic signed [33:0] yp, loss_w;
    logic signed [33:0] ydelta, m_sum;
    logic signed [31:0] m_new, s_new, init_m;
    logic signed [V_W:0] d_sum;
    logic [DIV_W-1:0]   divisor, dividend;
    logic               div_busy;
    logic [DIV_W-1:0]   quo;
    logic signed [31:0] quo_sat;

    assign col_ext    = EW'(r_col);
    assign row_ext    = EW'(r_row);
    assign col_ok     = col_ext < EW'(DIM);
    assign row_ok     = row_ext < EW'(DIM);
    assign col_idx    = col_ext[IW-1:0];
    assign model_addr = KW'(KW'(r_row) * KW'(DIM) + KW'(r_col));
    assign rd_addr    = i_ctl.rd_model ? model_addr : r_k;

    assign mulq_val = sat32($signed({{17{r_prod[64]}}, r_prod[64:16]}));
    assign sat_tp   = sat32($signed({{(66-ACC_W){r_tp[ACC_W-1]}}, r_tp}));
    assign sat_tn   = sat32($signed({{(66-ACC_W){r_tn[ACC_W-1]}}, r_tn}));

    always_comb begin
        mul_a = r_m;
        mul_b = {r_p[31], r_p};
        unique case (i_ctl.mul_sel)
            MS_M_P:  begin mul_a = r_m;    mul_b = {r_p[31], r_p}; end
            MS_M_N:  begin mul_a = r_m;    mul_b = {r_n[31], r_n}; end
            MS_Q_TP: begin mul_a = r_q;    mul_b = {sat_tp[31], sat_tp}; end
            MS_Q_TN: begin mul_a = r_q;    mul_b = {sat_tn[31], sat_tn}; end
            MS_Q_D:  begin mul_a = r_q;    mul_b = {r_p[31], r_p} - {r_n[31], r_n}; end
            MS_X_X:  begin mul_a = r_x;    mul_b = {r_x[31], r_x}; end
            MS_T_S:  begin mul_a = r_t1;   mul_b = {r_s[31], r_s}; end
            MS_MM_S: begin mul_a = r_mulm; mul_b = {r_s[31], r_s}; end
            MS_T_X:  begin mul_a = r_t1;   mul_b = {r_x[31], r_x}; end
            MS_S_X:  begin mul_a = r_s;    mul_b = {r_x[31], r_x}; end
            MS_T_T:  begin mul_a = r_t1;   mul_b = {r_t1[31], r_t1}; end
            MS_MS_T: begin mul_a = r_muls; mul_b = {r_t1[31], r_t1}; end
            default: begin mul_a = r_m;    mul_b = {r_p[31], r_p}; end
        endcase
    end

    // margin and hinge loss
    assign sp    = sat32($signed({{(66-ACC_W){r_accp[ACC_W-1]}}, r_accp}));
    assign sn    = sat32($signed({{(66-ACC_W){r_accn[ACC_W-1]}}, r_accn}));
    assign p_val = sat32($signed(66'($signed({sp[31], sp}) - $signed({sn[31], sn}))));
    always_comb begin
        if (r_y == 2'sd1) begin
            yp = 34'(p_val);
        end else if (r_y == 2'sd0) begin
            yp = '0;
        end else begin
            yp = -34'(p_val);
        end
        if (r_y == 2'sd1) begin
            ydelta = 34'(r_t1);
        end else if (r_y == 2'sd0) begin
            ydelta = '0;
        end else begin
            ydelta = -34'(r_t1);
        end
    end
    assign loss_w = 34'(Q_ONE) - yp;
    assign m_sum  = 34'(r_m) + ydelta;
    assign m_new  = sat32(66'(m_sum));
    assign s_new  = sat32(66'(34'(r_s) - 34'(mulq_val)));
    assign init_m = (r_i == r_j) ? Q_ONE : 32'sd0;

    // divisor and dividends
    assign d_sum    = (V_W+1)'(r_v) + $signed({{(V_W-30){1'b0}}, r_reg});
    assign divisor  = (d_sum <= 0) ? DIV_W'(1) : d_sum[DIV_W-1:0];
    assign dividend = i_ctl.div_m ? DIV_W'({r_loss[30:0], 16'h0000})
                                  : DIV_W'(48'h0001_0000_0000);
    assign quo_sat  = (quo > DIV_W'(32'h7fffffff)) ? SAT_MAX : quo[31:0];

    omcu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.div_go),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_busy     (div_busy),
        .o_quotient (quo)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg <= 31'd65536;
            r_i   <= '0;
            r_j   <= '0;
            r_k   <= '0;
            r_qv  <= '0;
            r_pv  <= '0;
            r_nv  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_reg <= i_cfg_wdata;
            end
            if (i_ctl.cnt_clr) begin
                r_i <= '0;
                r_j <= '0;
                r_k <= '0;
            end else if (i_ctl.cnt_step) begin
                if (r_k == KW'(DEPTH - 1)) begin
                    r_i <= '0;
                    r_j <= '0;
                    r_k <= '0;
                end else begin
                    r_k <= r_k + KW'(1);
                    if (r_j == IW'(DIM - 1)) begin
                        r_j <= '0;
                        r_i <= r_i + IW'(1);
                    end else begin
                        r_j <= r_j + IW'(1);
                    end
                end
            end
            if (i_ctl.vec_clr) begin
                r_qv <= '0;
                r_pv <= '0;
                r_nv <= '0;
            end else if (i_ctl.vec_wr && col_ok) begin
                if (r_cmd == CMD_LOAD_Q) begin
                    r_qv[col_idx] <= 1'b1;
                end
                if (r_cmd == CMD_LOAD_P) begin
                    r_pv[col_idx] <= 1'b1;
                end
                if (r_cmd == CMD_LOAD_N) begin
                    r_nv[col_idx] <= 1'b1;
                end
            end
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_ctl.init_wr) begin
            mem_m[r_k] <= init_m;
        end else if (i_ctl.wr_m) begin
            mem_m[r_k] <= m_new;
        end
        if (i_ctl.init_wr) begin
            mem_s[r_k] <= Q_ONE;
        end else if (i_ctl.wb_sel == WB_S) begin
            mem_s[r_k] <= s_new;
        end
        if (i_ctl.rd_model || i_ctl.rd_elem) begin
            r_m <= mem_m[rd_addr];
            r_s <= mem_s[rd_addr];
        end
        if (i_ctl.vec_wr && col_ok) begin
            if (r_cmd == CMD_LOAD_Q) begin
                vec_q[col_idx] <= r_val;
            end
            if (r_cmd == CMD_LOAD_P) begin
                vec_p[col_idx] <= r_val;
            end
            if (r_cmd == CMD_LOAD_N) begin
                vec_n[col_idx] <= r_val;
            end
        end
        if (i_ctl.rd_elem) begin
            r_q <= r_qv[r_i] ? vec_q[r_i] : 32'sd0;
            r_p <= r_pv[r_j] ? vec_p[r_j] : 32'sd0;
            r_n <= r_nv[r_j] ? vec_n[r_j] : 32'sd0;
        end
    end

    // arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd <= i_command;
            r_row <= i_row;
            r_col <= i_column;
            r_val <= i_element_value;
            r_y   <= (i_label == 2'sd1) ? 2'sd1 : ((i_label == 2'sd0) ? 2'sd0 : -2'sd1);
        end
        if (i_ctl.rd_model) begin
            r_rd_ok <= row_ok && col_ok;
        end
        if (i_ctl.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_ctl.acc_clr) begin
            r_tp   <= '0;
            r_tn   <= '0;
            r_accp <= '0;
            r_accn <= '0;
            r_v    <= '0;
        end else begin
            unique case (i_ctl.wb_sel)
                WB_TP:   r_tp   <= r_tp + ACC_W'(mulq_val);
                WB_TN:   r_tn   <= r_tn + ACC_W'(mulq_val);
                WB_ACCP: r_accp <= r_accp + ACC_W'(mulq_val);
                WB_ACCN: begin
                    r_accn <= r_accn + ACC_W'(mulq_val);
                    r_tp   <= '0;
                    r_tn   <= '0;
                end
                WB_X:    r_x  <= mulq_val;
                WB_T1:   r_t1 <= mulq_val;
                WB_V:    r_v  <= r_v + V_W'(mulq_val);
                WB_S:    ;
                WB_NONE: ;
                default: ;
            endcase
        end
        if (i_ctl.margin_ld) begin
            r_margin <= p_val;
            r_hinge  <= !loss_w[33] && (loss_w != '0);
            r_loss   <= sat32(66'(loss_w));
        end
        if (i_ctl.ld_mulm) begin
            r_mulm <= quo_sat;
        end
        if (i_ctl.ld_muls) begin
            r_muls <= quo_sat;
        end
        if (i_ctl.out_ld) begin
            unique case (i_ctl.out_sel)
                OUT_MODEL: begin
                    o_margin      <= '0;
                    o_updated     <= 1'b0;
                    o_model_value <= r_rd_ok ? r_m : 32'sd0;
                end
                OUT_TRAIN: begin
                    o_margin      <= r_margin;
                    o_updated     <= r_hinge;
                    o_model_value <= '0;
                end
                default: begin
                    o_margin      <= '0;
                    o_updated     <= 1'b0;
                    o_model_value <= '0;
                end
            endcase
        end
    end

    assign o_stat.cmd      = r_cmd;
    assign o_stat.last_j   = (r_j == IW'(DIM - 1));
    assign o_stat.last_k   = (r_k == KW'(DEPTH - 1));
    assign o_stat.hinge    = r_hinge;
    assign o_stat.div_busy = div_busy;

endmodule

FILE: rtl/omcu_ctrl.sv
`timescale 1ns / 1ps

module omcu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  omcu_pkg::t_stat  i_stat,
    output omcu_pkg::t_ctl   o_ctl,
    output logic             o_busy,
    output logic             o_valid
);
    import omcu_pkg::*;

    typedef enum logic [5:0] {
        S_INIT, S_IDLE, S_DECODE, S_RD_OUT,
        S_A_RD, S_A_MP, S_A_MN, S_A_AN, S_A_QP, S_A_QN, S_A_QE,
        S_MARGIN, S_HINGE,
        S_B_RD, S_B1, S_B2, S_B3, S_B4, S_B5, S_B6,
        S_DIV_M, S_DIV_MW, S_DIV_S, S_DIV_SW,
        S_C_RD, S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_C7, S_C8, S_C9, S_C10,
        S_C11, S_C12, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_valid;
    t_ctl   ctl;

    always_comb begin
        ctl     = '0;
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                ctl.init_wr  = 1'b1;
                ctl.cnt_step = 1'b1;
                if (i_stat.last_k) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                ctl.capture = 1'b1;
                if (i_start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                priority case (i_stat.cmd)
                    CMD_LOAD_Q, CMD_LOAD_P, CMD_LOAD_N: begin
                        ctl.vec_wr  = 1'b1;
                        ctl.out_ld  = 1'b1;
                        ctl.out_sel = OUT_ZERO;
                        n_state     = S_IDLE;
                    end
                    CMD_TRAIN: begin
                        ctl.acc_clr = 1'b1;
                        ctl.cnt_clr = 1'b1;
                        n_state     = S_A_RD;
                    end
                    CMD_READ: begin
                        ctl.rd_model = 1'b1;
                        n_state      = S_RD_OUT;
                    end
                    default: begin
                        ctl.out_ld  = 1'b1;
                        ctl.out_sel = OUT_ZERO;
                        n_state     = S_IDLE;
                    end
                endcase
            end
            S_RD_OUT: begin
                ctl.out_ld  = 1'b1;
                ctl.out_sel = OUT_MODEL;
                n_state     = S_IDLE;
            end
            // similarity pass
            S_A_RD: begin
                ctl.rd_elem = 1'b1;
                n_state     = S_A_MP;
            end
            S_A_MP: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MS_M_P;
                n_state     = S_A_MN;
            end
            S_A_MN: begin
                ctl.wb_sel  = WB_TP;
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MS_M_N;
                n_state     = S_A_AN;
            end
            S_A_AN: begin
                ctl.wb_sel = WB_TN;
                if (i_stat.last_j) begin
                    n_state = S_A_QP;
                end else begin
                    ctl.cnt_step = 1'b1;
                    n_state      = S_A_RD;
                end
            end
            S_A_QP: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MS_Q_TP;
                n_state     = S_A_QN;
            end
            S_A_QN: begin
                ctl.wb_sel  = WB_ACCP;
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MS_Q_TN;
                n_state     = S_A_QE;
            end
            S_A_QE: begin
                ctl.wb_sel   = WB_ACCN;
                ctl.cnt_step = 1'b1;
                n_state      = i_stat.last_k ? S_MARGIN : S_A_RD;
            end
            S_MARGIN: begin
                ctl.margin_ld = 1'b1;
                n_state       = S_HINGE;
            end
            S_HINGE: begin
                ctl.cnt_clr = 1'b1;
                n_state     = i_stat.hinge ? S_B_RD : S_FIN;
            end
            // weighted norm pass
            S_B_RD: begin
                ctl.rd_elem = 1'b1;
                n_state     = S_B1;
            end
            S_B1: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MS_Q_D;
                n_state     = S_B2;
            end
            S_B2: begin
                ctl.wb_sel = WB_X;
                n_state    = S_B3;
            end
            S_B3: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MS_X_X;
                n_state     = S_B4;
            end
            S_B4: begin
                ctl.wb_sel = WB_T1;
                n_state    = S_B5;
            end
            S_B5: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MS_T_S;
                n_state     = S_B6;
            end
            S_B6: begin
                ctl.wb_sel   = WB_V;
                ctl.cnt_step = 1'b1;
                n_state      = i_stat.last_k ? S_DIV_M : S_B_RD;
            end
            S_DIV_M: begin
                ctl.div_go = 1'b1;
                ctl.div_m  = 1'b1;
                n_state    = S_DIV_MW;
            end
            S_DIV_MW: begin
                if (!i_stat.div_busy) begin
                    ctl.ld_mulm = 1'b1;
                    n_state     = S_DIV_S;
                end
            end
            S_DIV_S: begin
                ctl.div_go = 1'b1;
                n_state    = S_DIV_SW;
            end
            S_DIV_SW: begin
                if (!i_stat.div_busy) begin
                    ctl.ld_muls = 1'b1;
                    ctl.cnt_clr = 1'b1;
                    n_state     = S_C_RD;
                end
            end
            // update pass
            S_C_RD: begin
                ctl.rd_elem = 1'b1;
                n_state     = S_C1;
            end
            S_C1: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MS_Q_D;
                n_state     = S_C2;
            end
            S_C2: begin
                ctl.wb_sel = WB_X;
                n_state    = S_C3;
            end
            S_C3: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MS_MM_S;
                n_state     = S_C4;
            end
            S_C4: begin
                ctl.wb_sel = WB_T1;
                n_state    = S_C5;
            end
            S_C5: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MS_T_X;
                n_state     = S_C6;
            end
            S_C6: begin
                ctl.wb_sel = WB_T1;
                n_state    = S_C7;
            end
            S_C7: begin
                ctl.wr_m    = 1'b1;
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MS_S_X;
                n_state     = S_C8;
            end
            S_C8: begin
                ctl.wb_sel = WB_T1;
                n_state    = S_C9;
            end
            S_C9: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MS_T_T;
                n_state     = S_C10;
            end
            S_C10: begin
                ctl.wb_sel = WB_T1;
                n_state    = S_C11;
            end
            S_C11: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MS_MS_T;
                n_state     = S_C12;
            end
            S_C12: begin
                ctl.wb_sel   = WB_S;
                ctl.cnt_step = 1'b1;
                n_state      = i_stat.last_k ? S_FIN : S_C_RD;
            end
            S_FIN: begin
                ctl.vec_clr = 1'b1;
                ctl.out_ld  = 1'b1;
                ctl.out_sel = OUT_TRAIN;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= ctl.out_ld;
        end
    end

    assign o_ctl   = ctl;
    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

FILE: rtl/online_metric_confidence_update.sv
`timescale 1ns / 1ps

// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+-------------------------------------------
// request   | in        | start high, busy low | i_command i_row i_column i_element_value i_label
// result    | out       | o_valid, one cycle   | o_margin o_updated o_model_value
// config    | in        | i_cfg_we             | i_cfg_wdata (regularizer)
//
// loads and unknown commands finish from the decode state, a model read from a read-out state after it
// train with no hinge loss runs only the similarity pass, all on the shared multiplier
// train with an update adds the weighted norm pass, two divisions and the update pass
// after reset an init pass loads the model memory with the identity and the confidence memory with Q_ONE
// the result receiver cannot stall; every request gives one result strobe

module online_metric_confidence_update #(
    parameter int DIM = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_command,
    input  logic [3:0]         i_row,
    input  logic [3:0]         i_column,
    input  logic signed [31:0] i_element_value,
    input  logic signed [1:0]  i_label,
    input  logic               i_cfg_we,
    input  logic [30:0]        i_cfg_wdata,
    output logic               o_valid,
    output logic signed [31:0] o_margin,
    output logic               o_updated,
    output logic signed [31:0] o_model_value
);
    import omcu_pkg::*;

    t_ctl  ctl;
    t_stat stat;

    omcu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    omcu_datapath #(
        .DIM (DIM)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_command       (i_command),
        .i_row           (i_row),
        .i_column        (i_column),
        .i_element_value (i_element_value),
        .i_label         (i_label),
        .o_margin        (o_margin),
        .o_updated       (o_updated),
        .o_model_value   (o_model_value)
    );

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    a_updated_only_train: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_updated |-> o_model_value == 32'sd0)
        else $error("update flag with model value");

endmodule
